/* rtl/core/scshu_pkg.sv */
// Shared types, widths and constants of the swept circle segment hit unit.
`timescale 1ns / 1ps
package scshu_pkg;

   localparam int COORD_W      = 19;
   localparam int VEL_W        = 22;
   localparam int DELTA_W      = 20;
   localparam int LEN_SQ_W     = 41;
   localparam int POINT_W      = 40;
   localparam int DOT_W        = 60;
   localparam int DIV_W        = 44;
   localparam int DIV_STEPS    = 16;
   localparam int QUO_W        = DIV_STEPS + 1;
   localparam int RADIUS_W     = 16;
   localparam int SETUP_STAGES = 4;
   localparam int POINT_STAGES = 5;
   localparam int DIST_STAGES  = 5;

   localparam logic [QUO_W-1:0]    Q_ONE        = QUO_W'(1) << DIV_STEPS;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(7168);

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type circle_last_x;
      coord_type circle_last_y;
      coord_type circle_now_x;
      coord_type circle_now_y;
      coord_type end_a_last_x;
      coord_type end_a_last_y;
      coord_type end_a_now_x;
      coord_type end_a_now_y;
      coord_type end_b_last_x;
      coord_type end_b_last_y;
      coord_type end_b_now_x;
      coord_type end_b_now_y;
   } req_type;

   // Geometry that travels alongside the divisions.
   typedef struct packed {
      logic signed [VEL_W-1:0]   rx;
      logic signed [VEL_W-1:0]   ry;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic signed [DELTA_W-1:0] mx;
      logic signed [DELTA_W-1:0] my;
      logic [LEN_SQ_W-1:0]       c;
      logic signed [POINT_W-1:0] qx;
      logic signed [POINT_W-1:0] qy;
   } side_type;

   typedef struct packed {
      logic [DIV_W-1:0]     rem;
      logic [DIV_W-1:0]     dvsr;
      logic [DIV_STEPS-1:0] feed;
      logic                 force_zero;
      logic                 force_one;
      side_type             side;
   } div_in_type;

   typedef struct packed {
      logic [DIV_W-1:0]     rem;
      logic [DIV_W-1:0]     dvsr;
      logic [DIV_STEPS-1:0] feed;
      logic [DIV_STEPS-1:0] quo;
      logic                 force_zero;
      logic                 force_one;
      side_type             side;
   } div_stage_type;

   typedef struct packed {
      logic [QUO_W-1:0] quo;
      side_type         side;
   } div_out_type;

endpackage

/* rtl/core/scshu_if.sv */
// Channel interfaces of the swept circle segment hit unit.
`timescale 1ns / 1ps
interface scshu_req_if;
   import scshu_pkg::*;
   logic      valid;
   logic      ready;
   coord_type circle_last_x;
   coord_type circle_last_y;
   coord_type circle_now_x;
   coord_type circle_now_y;
   coord_type end_a_last_x;
   coord_type end_a_last_y;
   coord_type end_a_now_x;
   coord_type end_a_now_y;
   coord_type end_b_last_x;
   coord_type end_b_last_y;
   coord_type end_b_now_x;
   coord_type end_b_now_y;
   modport source (output valid, output circle_last_x, output circle_last_y,
      output circle_now_x, output circle_now_y, output end_a_last_x,
      output end_a_last_y, output end_a_now_x, output end_a_now_y,
      output end_b_last_x, output end_b_last_y, output end_b_now_x,
      output end_b_now_y, input ready);
   modport sink (input valid, input circle_last_x, input circle_last_y,
      input circle_now_x, input circle_now_y, input end_a_last_x,
      input end_a_last_y, input end_a_now_x, input end_a_now_y,
      input end_b_last_x, input end_b_last_y, input end_b_now_x,
      input end_b_now_y, output ready);
endinterface

interface scshu_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   modport source (output valid, output hit, input ready);
   modport sink (input valid, input hit, output ready);
endinterface

interface scshu_csr_if;
   import scshu_pkg::*;
   logic                valid;
   logic                ready;
   logic [RADIUS_W-1:0] circle_radius;
   modport source (output valid, output circle_radius, input ready);
   modport sink (input valid, input circle_radius, output ready);
endinterface

/* rtl/core/swept_circle_segment_hit_unit.sv */
// Top level of the swept circle versus moving segment hit unit.
`timescale 1ns / 1ps
// Usage:
// The req channel carries one item per query: the previous and current centers of
// a circle and the previous and current positions of a segment's two endpoints,
// all 19-bit two's complement with 8 fraction bits. The rsp channel returns one
// item per query with a single hit bit, in the order the queries were accepted.
// The csr channel writes the circle radius; it is always ready and must only be
// written while no query is in flight.
// From acceptance to the result on rsp an item passes 4 setup stages, a 16-stage
// divider for the approach time, 5 projection stages, a 16-stage divider for the
// segment parameter and 5 distance stages. The pipeline accepts one item every
// cycle unless the receiver stalls; each divider retires one quotient bit per stage.
// Each stage has its own valid bit and moves forward when the stage after it is
// empty or moving, so bubbles are squeezed out. When the receiver stalls, results
// stay in the final register and items back up stage by stage; req ready only
// drops once every stage holds an item. Nothing is lost or repeated.
// Reset clears all valid bits and restores the radius to 7168 (28.0 units).
module swept_circle_segment_hit_unit import scshu_pkg::*; (
   input logic           clock,
   input logic           reset,
   scshu_req_if.sink     req_if,
   scshu_rsp_if.source   rsp_if,
   scshu_csr_if.sink     csr_if
);

   // Radius register.
   logic [RADIUS_W-1:0] radius_ff;
   logic [RADIUS_W-1:0] radius_in;

   assign csr_if.ready = 1'b1;
   assign radius_in = (csr_if.valid && csr_if.ready) ? csr_if.circle_radius : radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else begin
         radius_ff <= radius_in;
      end
   end

   // Gather the request fields into one item.
   req_type req_item;

   always_comb begin
      req_item.circle_last_x = req_if.circle_last_x;
      req_item.circle_last_y = req_if.circle_last_y;
      req_item.circle_now_x  = req_if.circle_now_x;
      req_item.circle_now_y  = req_if.circle_now_y;
      req_item.end_a_last_x  = req_if.end_a_last_x;
      req_item.end_a_last_y  = req_if.end_a_last_y;
      req_item.end_a_now_x   = req_if.end_a_now_x;
      req_item.end_a_now_y   = req_if.end_a_now_y;
      req_item.end_b_last_x  = req_if.end_b_last_x;
      req_item.end_b_last_y  = req_if.end_b_last_y;
      req_item.end_b_now_x   = req_if.end_b_now_x;
      req_item.end_b_now_y   = req_if.end_b_now_y;
   end

   logic        tdiv_in_valid, tdiv_in_ready;
   div_in_type  tdiv_in;
   logic        tdiv_out_valid, tdiv_out_ready;
   div_out_type tdiv_out;
   logic        sdiv_in_valid, sdiv_in_ready;
   div_in_type  sdiv_in;
   logic        sdiv_out_valid, sdiv_out_ready;
   div_out_type sdiv_out;

   scshu_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_data   (req_item),
      .out_valid (tdiv_in_valid),
      .out_ready (tdiv_in_ready),
      .out_data  (tdiv_in)
   );

   // Closest-approach time t.
   scshu_divider u_tdiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tdiv_in_valid),
      .in_ready  (tdiv_in_ready),
      .in_data   (tdiv_in),
      .out_valid (tdiv_out_valid),
      .out_ready (tdiv_out_ready),
      .out_data  (tdiv_out)
   );

   scshu_point u_point (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tdiv_out_valid),
      .in_ready  (tdiv_out_ready),
      .in_data   (tdiv_out),
      .out_valid (sdiv_in_valid),
      .out_ready (sdiv_in_ready),
      .out_data  (sdiv_in)
   );

   // Segment parameter s of the projection.
   scshu_divider u_sdiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sdiv_in_valid),
      .in_ready  (sdiv_in_ready),
      .in_data   (sdiv_in),
      .out_valid (sdiv_out_valid),
      .out_ready (sdiv_out_ready),
      .out_data  (sdiv_out)
   );

   scshu_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .radius    (radius_ff),
      .in_valid  (sdiv_out_valid),
      .in_ready  (sdiv_out_ready),
      .in_data   (sdiv_out),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_hit   (rsp_if.hit)
   );

`ifndef SYNTHESIS
   a_radius_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> radius_ff == RADIUS_RESET)
      else $error("radius not restored by reset");

   a_radius_write: assert property (@(posedge clock) disable iff (reset)
      csr_if.valid && csr_if.ready |=> radius_ff == $past(csr_if.circle_radius))
      else $error("radius write lost");

   a_no_result_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("result present right after reset");
`endif

endmodule

/* rtl/core/scshu_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps
module scshu_divider import scshu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  div_in_type  in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output div_out_type out_data
);

   div_stage_type        stage_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] vld_ff;
   logic [DIV_STEPS-1:0] vld_in;
   logic [DIV_STEPS:0]   rdy;

   assign rdy[DIV_STEPS]     = out_ready;
   assign rdy[DIV_STEPS-1:0] = ~vld_ff | rdy[DIV_STEPS:1];
   assign vld_in = (rdy[DIV_STEPS-1:0] & {vld_ff[DIV_STEPS-2:0], in_valid}) |
                   (~rdy[DIV_STEPS-1:0] & vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      div_stage_type    src;
      div_stage_type    step_in;
      logic [DIV_W-1:0] trial;
      logic             ge;

      if (k == 0) begin : g_first
         assign src = {in_data.rem, in_data.dvsr, in_data.feed, {DIV_STEPS{1'b0}},
                       in_data.force_zero, in_data.force_one, in_data.side};
      end else begin : g_next
         assign src = stage_ff[k-1];
      end

      // Shift the next dividend bit into the partial remainder, subtract if it fits.
      always_comb begin
         trial           = {src.rem[DIV_W-2:0], src.feed[DIV_STEPS-1]};
         ge              = (trial >= src.dvsr);
         step_in         = src;
         step_in.rem     = ge ? (trial - src.dvsr) : trial;
         step_in.feed    = {src.feed[DIV_STEPS-2:0], 1'b0};
         step_in.quo     = {src.quo[DIV_STEPS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            stage_ff[k] <= step_in;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[DIV_STEPS-1];

   always_comb begin
      out_data.side = stage_ff[DIV_STEPS-1].side;
      if (stage_ff[DIV_STEPS-1].force_one) begin
         out_data.quo = Q_ONE;
      end else if (stage_ff[DIV_STEPS-1].force_zero) begin
         out_data.quo = '0;
      end else begin
         out_data.quo = {1'b0, stage_ff[DIV_STEPS-1].quo};
      end
   end

endmodule

/* rtl/core/scshu_setup.sv */
// Front stages: relative velocity, cross products and the time division operands.
`timescale 1ns / 1ps
module scshu_setup import scshu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  req_type    in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output div_in_type out_data
);

   logic [SETUP_STAGES-1:0] vld_ff;
   logic [SETUP_STAGES-1:0] vld_in;
   logic [SETUP_STAGES:0]   rdy;

   assign rdy[SETUP_STAGES]     = out_ready;
   assign rdy[SETUP_STAGES-1:0] = ~vld_ff | rdy[SETUP_STAGES:1];
   assign vld_in = (rdy[SETUP_STAGES-1:0] & {vld_ff[SETUP_STAGES-2:0], in_valid}) |
                   (~rdy[SETUP_STAGES-1:0] & vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: differences.
   logic signed [DELTA_W-1:0] dcx, dcy, dax, day, dbx, dby;
   side_type                  s1_in, s1_ff;

   always_comb begin
      dcx = DELTA_W'(in_data.circle_now_x) - DELTA_W'(in_data.circle_last_x);
      dcy = DELTA_W'(in_data.circle_now_y) - DELTA_W'(in_data.circle_last_y);
      dax = DELTA_W'(in_data.end_a_now_x) - DELTA_W'(in_data.end_a_last_x);
      day = DELTA_W'(in_data.end_a_now_y) - DELTA_W'(in_data.end_a_last_y);
      dbx = DELTA_W'(in_data.end_b_now_x) - DELTA_W'(in_data.end_b_last_x);
      dby = DELTA_W'(in_data.end_b_now_y) - DELTA_W'(in_data.end_b_last_y);
      s1_in    = '0;
      s1_in.rx = (VEL_W'(dcx) <<< 1) - (VEL_W'(dax) + VEL_W'(dbx));
      s1_in.ry = (VEL_W'(dcy) <<< 1) - (VEL_W'(day) + VEL_W'(dby));
      s1_in.dx = DELTA_W'(in_data.end_b_last_x) - DELTA_W'(in_data.end_a_last_x);
      s1_in.dy = DELTA_W'(in_data.end_b_last_y) - DELTA_W'(in_data.end_a_last_y);
      s1_in.mx = DELTA_W'(in_data.circle_last_x) - DELTA_W'(in_data.end_a_last_x);
      s1_in.my = DELTA_W'(in_data.circle_last_y) - DELTA_W'(in_data.end_a_last_y);
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_ff <= s1_in;
      end
   end

   // Stage 2: products.
   logic signed [2*VEL_W-3:0]  p_rdy_ff, p_ryd_ff;
   logic signed [2*DELTA_W-1:0] p_dmy_ff, p_dym_ff, p_dxx_ff, p_dyy_ff;
   side_type                    s2_ff;

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         p_rdy_ff <= (2*VEL_W-2)'(s1_ff.rx) * (2*VEL_W-2)'(s1_ff.dy);
         p_ryd_ff <= (2*VEL_W-2)'(s1_ff.ry) * (2*VEL_W-2)'(s1_ff.dx);
         p_dmy_ff <= (2*DELTA_W)'(s1_ff.dx) * (2*DELTA_W)'(s1_ff.my);
         p_dym_ff <= (2*DELTA_W)'(s1_ff.dy) * (2*DELTA_W)'(s1_ff.mx);
         p_dxx_ff <= (2*DELTA_W)'(s1_ff.dx) * (2*DELTA_W)'(s1_ff.dx);
         p_dyy_ff <= (2*DELTA_W)'(s1_ff.dy) * (2*DELTA_W)'(s1_ff.dy);
         s2_ff    <= s1_ff;
      end
   end

   // Stage 3: cross(r,d), cross(d,m) and |d|^2.
   logic signed [2*VEL_W-2:0]   crd_ff;
   logic signed [2*DELTA_W:0]   cdm_ff;
   side_type                    s3_in, s3_ff;

   always_comb begin
      s3_in   = s2_ff;
      s3_in.c = LEN_SQ_W'(unsigned'(p_dxx_ff)) + LEN_SQ_W'(unsigned'(p_dyy_ff));
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         crd_ff <= (2*VEL_W-1)'(p_rdy_ff) - (2*VEL_W-1)'(p_ryd_ff);
         cdm_ff <= (2*DELTA_W+1)'(p_dmy_ff) - (2*DELTA_W+1)'(p_dym_ff);
         s3_ff  <= s3_in;
      end
   end

   // Stage 4: magnitudes and the special cases of t.
   logic [2*VEL_W-2:0] crd_mag;
   logic [2*DELTA_W:0] cdm_mag;
   logic [DIV_W-1:0]   rem0;
   div_in_type         s4_in, s4_ff;

   always_comb begin
      crd_mag          = crd_ff[2*VEL_W-2] ? unsigned'(-crd_ff) : unsigned'(crd_ff);
      cdm_mag          = cdm_ff[2*DELTA_W] ? unsigned'(-cdm_ff) : unsigned'(cdm_ff);
      rem0             = DIV_W'({cdm_mag, 1'b0});
      s4_in.rem        = rem0;
      s4_in.dvsr       = DIV_W'(crd_mag);
      s4_in.feed       = '0;
      s4_in.force_zero = (crd_ff == '0) || (cdm_ff == '0) ||
                         (crd_ff[2*VEL_W-2] != cdm_ff[2*DELTA_W]);
      s4_in.force_one  = !s4_in.force_zero && (rem0 >= DIV_W'(crd_mag));
      s4_in.side       = s3_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s4_ff <= s4_in;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[SETUP_STAGES-1];
   assign out_data  = s4_ff;

endmodule

/* rtl/core/scshu_point.sv */
// Middle stages: point at t and the projection operands for s.
`timescale 1ns / 1ps
module scshu_point import scshu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  div_out_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output div_in_type  out_data
);

   logic [POINT_STAGES-1:0] vld_ff;
   logic [POINT_STAGES-1:0] vld_in;
   logic [POINT_STAGES:0]   rdy;

   assign rdy[POINT_STAGES]     = out_ready;
   assign rdy[POINT_STAGES-1:0] = ~vld_ff | rdy[POINT_STAGES:1];
   assign vld_in = (rdy[POINT_STAGES-1:0] & {vld_ff[POINT_STAGES-2:0], in_valid}) |
                   (~rdy[POINT_STAGES-1:0] & vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: r * t.
   logic signed [QUO_W:0]     t_s;
   logic signed [POINT_W-1:0] px_ff, py_ff;
   side_type                  s1_ff;

   assign t_s = signed'({1'b0, in_data.quo});

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         px_ff <= POINT_W'(in_data.side.rx) * POINT_W'(t_s);
         py_ff <= POINT_W'(in_data.side.ry) * POINT_W'(t_s);
         s1_ff <= in_data.side;
      end
   end

   // Stage 2: point relative to A0 with 17 more fraction bits.
   side_type s2_in, s2_ff;

   always_comb begin
      s2_in    = s1_ff;
      s2_in.qx = (POINT_W'(s1_ff.mx) <<< (DIV_STEPS + 1)) + px_ff;
      s2_in.qy = (POINT_W'(s1_ff.my) <<< (DIV_STEPS + 1)) + py_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s2_ff <= s2_in;
      end
   end

   // Stage 3: dot product terms.
   logic signed [DOT_W-1:0] ax_ff, ay_ff;
   side_type                s3_ff;

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         ax_ff <= DOT_W'(s2_ff.qx) * DOT_W'(s2_ff.dx);
         ay_ff <= DOT_W'(s2_ff.qy) * DOT_W'(s2_ff.dy);
         s3_ff <= s2_ff;
      end
   end

   // Stage 4: dot product and divisor 2|d|^2.
   logic signed [DOT_W-1:0] dp_ff;
   logic [LEN_SQ_W:0]       den_ff;
   side_type                s4_ff;

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         dp_ff  <= ax_ff + ay_ff;
         den_ff <= {s3_ff.c, 1'b0};
         s4_ff  <= s3_ff;
      end
   end

   // Stage 5: special cases of s and division operands.
   logic       dp_pos;
   div_in_type s5_in, s5_ff;

   always_comb begin
      dp_pos           = !dp_ff[DOT_W-1] && (dp_ff != '0);
      s5_in.rem        = DIV_W'(unsigned'(dp_ff) >> DIV_STEPS);
      s5_in.dvsr       = DIV_W'(den_ff);
      s5_in.feed       = dp_ff[DIV_STEPS-1:0];
      s5_in.force_zero = (s4_ff.c == '0) || !dp_pos;
      s5_in.force_one  = !s5_in.force_zero &&
                         (unsigned'(dp_ff) >= DOT_W'({den_ff, {DIV_STEPS{1'b0}}}));
      s5_in.side       = s4_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s5_ff <= s5_in;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[POINT_STAGES-1];
   assign out_data  = s5_ff;

endmodule

/* rtl/core/scshu_dist.sv */
// Back stages: offset to the closest segment point and the radius compare.
`timescale 1ns / 1ps
module scshu_dist import scshu_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [RADIUS_W-1:0] radius,
   input  logic                in_valid,
   output logic                in_ready,
   input  div_out_type         in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output logic                out_hit
);

   localparam int MS_W  = DELTA_W + QUO_W + 1;
   localparam int ERR_W = POINT_W + 1;
   localparam int U_W   = 31;
   localparam int SQ_W  = 2 * U_W;

   logic [DIST_STAGES-1:0] vld_ff;
   logic [DIST_STAGES-1:0] vld_in;
   logic [DIST_STAGES:0]   rdy;

   assign rdy[DIST_STAGES]     = out_ready;
   assign rdy[DIST_STAGES-1:0] = ~vld_ff | rdy[DIST_STAGES:1];
   assign vld_in = (rdy[DIST_STAGES-1:0] & {vld_ff[DIST_STAGES-2:0], in_valid}) |
                   (~rdy[DIST_STAGES-1:0] & vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Radius squared; users must change radius only while the block is idle (unchecked).
   logic [2*RADIUS_W-1:0] rad_sq_ff;

   always_ff @(posedge clock) begin
      rad_sq_ff <= (2*RADIUS_W)'(radius) * (2*RADIUS_W)'(radius);
   end

   // Stage 1: d * s.
   logic signed [QUO_W:0]  s_s;
   logic signed [MS_W-1:0] msx_ff, msy_ff;
   logic signed [POINT_W-1:0] qx1_ff, qy1_ff;

   assign s_s = signed'({1'b0, in_data.quo});

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         msx_ff <= MS_W'(in_data.side.dx) * MS_W'(s_s);
         msy_ff <= MS_W'(in_data.side.dy) * MS_W'(s_s);
         qx1_ff <= in_data.side.qx;
         qy1_ff <= in_data.side.qy;
      end
   end

   // Stage 2: offset from the segment point.
   logic signed [ERR_W-1:0] ex_ff, ey_ff;

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         ex_ff <= ERR_W'(qx1_ff) - (ERR_W'(msx_ff) <<< 1);
         ey_ff <= ERR_W'(qy1_ff) - (ERR_W'(msy_ff) <<< 1);
      end
   end

   // Stage 3: magnitudes, low bits dropped.
   logic [ERR_W-1:0] mx_mag, my_mag;
   logic [U_W-1:0]   ux_ff, uy_ff;

   always_comb begin
      mx_mag = ex_ff[ERR_W-1] ? unsigned'(-ex_ff) : unsigned'(ex_ff);
      my_mag = ey_ff[ERR_W-1] ? unsigned'(-ey_ff) : unsigned'(ey_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         ux_ff <= mx_mag[U_W+8:9];
         uy_ff <= my_mag[U_W+8:9];
      end
   end

   // Stage 4: squares.
   logic [SQ_W-1:0] sqx_ff, sqy_ff;

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         sqx_ff <= SQ_W'(ux_ff) * SQ_W'(ux_ff);
         sqy_ff <= SQ_W'(uy_ff) * SQ_W'(uy_ff);
      end
   end

   // Stage 5: inclusive compare against radius^2 scaled by 2^16; also the output register.
   logic hit_ff;

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         hit_ff <= ((SQ_W+1)'(sqx_ff) + (SQ_W+1)'(sqy_ff)) <=
                   (SQ_W+1)'({rad_sq_ff, {DIV_STEPS{1'b0}}});
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[DIST_STAGES-1];
   assign out_hit   = hit_ff;

endmodule

/* dv/scshu_hit_checker.sv */
// Checker of the swept circle segment hit unit: predicts each hit bit and compares.
`timescale 1ns / 1ps
module scshu_hit_checker import scshu_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   scshu_req_if  req_if,
   scshu_rsp_if  rsp_if,
   scshu_csr_if  csr_if,
   output int    mismatch_count,
   output int    hits_pending
);

   localparam longint unsigned ONE_Q16 = 64'd65536;

   logic [RADIUS_W-1:0] radius_now;
   bit                  expected_hits[$];

   function automatic longint unsigned abs_val(input longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   // Closest approach time along the relative path, then projection onto the
   // segment at its previous position, then the squared distance test.
   function automatic bit predict_hit(input req_type q, input logic [RADIUS_W-1:0] rad);
      longint rx, ry, dx, dy, mx, my, crd, cdm, qx, qy, seg_len_sq, dp, ex, ey;
      longint unsigned t_q16, s_q16, quo, den, ux, uy, dist_sq, lim;
      rx = 2 * (longint'(q.circle_now_x) - longint'(q.circle_last_x))
         - ((longint'(q.end_a_now_x) - longint'(q.end_a_last_x))
          + (longint'(q.end_b_now_x) - longint'(q.end_b_last_x)));
      ry = 2 * (longint'(q.circle_now_y) - longint'(q.circle_last_y))
         - ((longint'(q.end_a_now_y) - longint'(q.end_a_last_y))
          + (longint'(q.end_b_now_y) - longint'(q.end_b_last_y)));
      dx = longint'(q.end_b_last_x) - longint'(q.end_a_last_x);
      dy = longint'(q.end_b_last_y) - longint'(q.end_a_last_y);
      mx = longint'(q.circle_last_x) - longint'(q.end_a_last_x);
      my = longint'(q.circle_last_y) - longint'(q.end_a_last_y);
      crd = rx * dy - ry * dx;
      cdm = dx * my - dy * mx;
      t_q16 = 0;
      if (crd != 0 && cdm != 0 && ((crd < 0) == (cdm < 0))) begin
         quo = (abs_val(cdm) << 17) / abs_val(crd);
         t_q16 = (quo > ONE_Q16) ? ONE_Q16 : quo;
      end
      qx = mx * 131072 + rx * longint'(t_q16);
      qy = my * 131072 + ry * longint'(t_q16);
      seg_len_sq = dx * dx + dy * dy;
      s_q16 = 0;
      if (seg_len_sq != 0) begin
         dp = qx * dx + qy * dy;
         if (dp > 0) begin
            den = 2 * longint'(seg_len_sq);
            if (longint'(dp) >= den * ONE_Q16) s_q16 = ONE_Q16;
            else s_q16 = longint'(dp) / den;
         end
      end
      ex = qx - 2 * dx * longint'(s_q16);
      ey = qy - 2 * dy * longint'(s_q16);
      ux = abs_val(ex) >> 9;
      uy = abs_val(ey) >> 9;
      dist_sq = ux * ux + uy * uy;
      lim = (longint'(rad) * longint'(rad)) << 16;
      return dist_sq <= lim;
   endfunction

   always @(posedge clock) begin
      req_type q;
      bit want;
      if (reset) begin
         radius_now <= RADIUS_RESET;
         mismatch_count = 0;
      end else begin
         if (csr_if.valid && csr_if.ready) radius_now <= csr_if.circle_radius;
         if (req_if.valid && req_if.ready) begin
            q = '{req_if.circle_last_x, req_if.circle_last_y, req_if.circle_now_x,
                  req_if.circle_now_y, req_if.end_a_last_x, req_if.end_a_last_y,
                  req_if.end_a_now_x, req_if.end_a_now_y, req_if.end_b_last_x,
                  req_if.end_b_last_y, req_if.end_b_now_x, req_if.end_b_now_y};
            expected_hits.push_back(predict_hit(q, radius_now));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_hits.size() == 0) begin
               $display("%0t: unexpected item, hit=%0b", $time, rsp_if.hit);
               mismatch_count++;
            end else begin
               want = expected_hits.pop_front();
               if (rsp_if.hit !== want) begin
                  $display("%0t: hit mismatch, expected %0b actual %0b",
                           $time, want, rsp_if.hit);
                  mismatch_count++;
               end
            end
         end
      end
      hits_pending = expected_hits.size();
   end

endmodule

/* dv/tb_swept_circle_segment_hit_unit.sv */
// Testbench top of the swept circle segment hit unit: stimulus and verdict.
`timescale 1ns / 1ps
module tb_swept_circle_segment_hit_unit;
   import scshu_pkg::*;

   // Wait after the last expected result so the pipeline drains with margin.
   localparam int DRAIN_CYCLES = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatch_count;
   int   hits_pending;

   // Percent of cycles in which the sender and the receiver hold back.
   int   req_idle_pct = 36;
   int   rsp_idle_pct = 70;
   // Set by the pressure process to freeze the receiver for a long stretch.
   logic rsp_hold = 1'b0;

   scshu_req_if req_if ();
   scshu_rsp_if rsp_if ();
   scshu_csr_if csr_if ();

   always #5 clock = ~clock;

   swept_circle_segment_hit_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   scshu_hit_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .csr_if         (csr_if),
      .mismatch_count (mismatch_count),
      .hits_pending   (hits_pending)
   );

   // The receiver decides its ready every cycle; the hold flag overrides it.
   always @(posedge clock) begin
      rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
   end

   // Builds one query from twelve integers; each wraps to the low 19 bits.
   function automatic req_type make_query(input int clx, cly, cnx, cny, alx, aly,
                                          anx, any, blx, bly, bnx, bny);
      return '{coord_type'(clx), coord_type'(cly), coord_type'(cnx), coord_type'(cny),
               coord_type'(alx), coord_type'(aly), coord_type'(anx), coord_type'(any),
               coord_type'(blx), coord_type'(bly), coord_type'(bnx), coord_type'(bny)};
   endfunction

   function automatic int jitter(input int base, input int spread);
      return base + int'($urandom_range(2 * spread)) - spread;
   endfunction

   // Offers one item, idling first at the current rate, and returns once the
   // block has accepted it. Valid stays high so back to back items stream.
   task automatic send_query(input req_type q);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.circle_last_x <= q.circle_last_x;
      req_if.circle_last_y <= q.circle_last_y;
      req_if.circle_now_x  <= q.circle_now_x;
      req_if.circle_now_y  <= q.circle_now_y;
      req_if.end_a_last_x  <= q.end_a_last_x;
      req_if.end_a_last_y  <= q.end_a_last_y;
      req_if.end_a_now_x   <= q.end_a_now_x;
      req_if.end_a_now_y   <= q.end_a_now_y;
      req_if.end_b_last_x  <= q.end_b_last_x;
      req_if.end_b_last_y  <= q.end_b_last_y;
      req_if.end_b_now_x   <= q.end_b_now_x;
      req_if.end_b_now_y   <= q.end_b_now_y;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // The radius may only change while nothing is in flight, so drain first.
   task automatic write_radius(input logic [RADIUS_W-1:0] radius);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (hits_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_if.valid         <= 1'b1;
      csr_if.circle_radius <= radius;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   // Random queries. Most are local scenes where the circle and the segment
   // lie within a few radii of each other, so hits and misses both occur.
   // The rest use the full coordinate range, or degenerate and static cases.
   task automatic send_random(input int count);
      int kind, bx, by, sp, mv;
      int clx, cly, alx, aly, blx, bly;
      req_type q;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         bx = int'($urandom_range(524287)) - 262144;
         by = int'($urandom_range(524287)) - 262144;
         sp = 1 << $urandom_range(15, 4);
         mv = 1 << $urandom_range(14, 2);
         clx = jitter(bx, sp); cly = jitter(by, sp);
         alx = jitter(bx, sp); aly = jitter(by, sp);
         blx = jitter(bx, sp); bly = jitter(by, sp);
         if (kind < 20) begin
            q = make_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end else if (kind < 28) begin
            // Degenerate segment: both ends start at the same point.
            q = make_query(clx, cly, jitter(clx, mv), jitter(cly, mv), alx, aly,
                           jitter(alx, mv), jitter(aly, mv), alx, aly,
                           jitter(alx, mv), jitter(aly, mv));
         end else if (kind < 36) begin
            // Static scene: nothing moves, so the approach time is zero.
            q = make_query(clx, cly, clx, cly, alx, aly, alx, aly, blx, bly, blx, bly);
         end else begin
            q = make_query(clx, cly, jitter(clx, mv), jitter(cly, mv),
                           alx, aly, jitter(alx, mv), jitter(aly, mv),
                           blx, bly, jitter(blx, mv), jitter(bly, mv));
         end
         send_query(q);
      end
   endtask

   // Long receiver stall while the sender keeps offering, so the pipeline fills
   // and the block must drop its input ready.
   initial begin
      wait (req_idle_pct == 0 && rsp_idle_pct == 0);
      repeat (200) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.circle_last_x = '0; req_if.circle_last_y = '0;
      req_if.circle_now_x  = '0; req_if.circle_now_y  = '0;
      req_if.end_a_last_x  = '0; req_if.end_a_last_y  = '0;
      req_if.end_a_now_x   = '0; req_if.end_a_now_y   = '0;
      req_if.end_b_last_x  = '0; req_if.end_b_last_y  = '0;
      req_if.end_b_now_x   = '0; req_if.end_b_now_y   = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.circle_radius = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset radius of 28 units (7168).
      send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_query(make_query(262143, 262143, 262143, 262143, 262143, 262143,
                            262143, 262143, 262143, 262143, 262143, 262143));
      send_query(make_query(-262144, -262144, -262144, -262144, -262144, -262144,
                            -262144, -262144, -262144, -262144, -262144, -262144));
      // Extremes far apart: largest products in every stage.
      send_query(make_query(-262144, 262143, 262143, -262144, 262143, -262144,
                            -262144, 262143, -262144, -262144, 262143, 262143));
      send_query(make_query(262143, -262144, -262144, 262143, -262144, 262143,
                            262143, -262144, 262143, 262143, -262144, -262144));
      // Circle sitting on a static segment.
      send_query(make_query(1280, 0, 1280, 0, 0, 0, 0, 0, 2560, 0, 2560, 0));
      // Circle crossing the segment during the step.
      send_query(make_query(1280, -12800, 1280, 12800, 0, 0, 0, 0, 2560, 0, 2560, 0));
      // Motion parallel to the segment: zero denominator.
      send_query(make_query(0, 12800, 25600, 12800, 0, 0, 0, 0, 2560, 0, 2560, 0));
      // Moving away from the line: approach time would be negative.
      send_query(make_query(1280, 6400, 1280, 12800, 0, 0, 0, 0, 2560, 0, 2560, 0));
      // Moving toward the line but falling short: approach time past one.
      send_query(make_query(1280, 25600, 1280, 19200, 0, 0, 0, 0, 2560, 0, 2560, 0));
      // Circle exactly on the line: zero numerator.
      send_query(make_query(1280, 0, 1280, 2560, 0, 0, 0, 0, 2560, 0, 2560, 0));
      // Degenerate segment, with and without contact.
      send_query(make_query(500, 500, 600, 600, 0, 0, 0, 0, 0, 0, 0, 0));
      send_query(make_query(50000, 500, 50000, 600, 0, 0, 0, 0, 0, 0, 0, 0));
      // Projection before end A and beyond end B.
      send_query(make_query(-5000, 0, -5000, 0, 0, 0, 0, 0, 2560, 0, 2560, 0));
      send_query(make_query(9000, 0, 9000, 0, 0, 0, 0, 0, 2560, 0, 2560, 0));
      // Distance exactly at the radius, just inside and just outside.
      send_query(make_query(1280, 7168, 1280, 7168, 0, 0, 0, 0, 2560, 0, 2560, 0));
      send_query(make_query(1280, 7169, 1280, 7169, 0, 0, 0, 0, 2560, 0, 2560, 0));
      send_query(make_query(1280, -7167, 1280, -7167, 0, 0, 0, 0, 2560, 0, 2560, 0));
      // Segment sweeping over a static circle.
      send_query(make_query(1280, 5000, 1280, 5000, 0, 0, 0, 20000, 2560, 0, 2560, 20000));
      // Coordinates wrapping across the sign boundary.
      send_query(make_query(262100, 0, -262100, 0, 262000, 100, -262000, 100,
                            262000, -100, -262000, -100));
      send_random(240);

      // Zero radius: only an exact touch counts.
      write_radius('0);
      req_idle_pct = 70;
      rsp_idle_pct = 36;
      send_query(make_query(1280, 0, 1280, 0, 0, 0, 0, 0, 2560, 0, 2560, 0));
      send_query(make_query(1280, 1, 1280, 1, 0, 0, 0, 0, 2560, 0, 2560, 0));
      send_random(240);

      // Largest radius.
      write_radius('1);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_random(260);

      write_radius(RADIUS_W'($urandom_range(65535)));
      send_random(140);
      write_radius(RADIUS_W'($urandom_range(255, 1)));
      send_random(130);

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (hits_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && hits_pending == 0) begin
         $display("tb_swept_circle_segment_hit_unit passed");
      end else begin
         $display("tb_swept_circle_segment_hit_unit failed");
      end
      $finish;
   end

   // Guard against a hang: far beyond the slowest correct run.
   initial begin
      #3ms;
      $display("tb_swept_circle_segment_hit_unit failed");
      $finish;
   end

endmodule
